// File: design/arcsin_arccos_poly_sqrt_approx_assert.svh
// Assertion macros for the arcsine/arccosine approximation pipeline.
// Included by the top level; needs nothing else.
`ifndef ARCSIN_ARCCOS_POLY_SQRT_APPROX_ASSERT_SVH
`define ARCSIN_ARCCOS_POLY_SQRT_APPROX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASAC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASAC_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/asac_pkg.sv
// Constants, types and the square-root digit step for the arcsine/arccosine pipeline.
// Stands alone; used by arcsin_arccos_poly_sqrt_approx.
`default_nettype none

package asac_pkg;

  typedef enum logic {
    REQ_ACOS = 1'b0,
    REQ_ASIN = 1'b1
  } req_e;

  localparam logic [14:0] ONE_Q14 = 15'd16384;

  // Polynomial coefficients in Q.16, rounded to nearest.
  localparam logic [10:0] COEF3 = 11'd1227;
  localparam logic [12:0] COEF2 = 13'd4867;
  localparam logic [13:0] COEF1 = 14'd13901;
  localparam logic [16:0] COEF0 = 17'd102939;

  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

  localparam int unsigned ROOT_STEPS    = 15;
  localparam int unsigned STEPS_PER_STG = 3;

  typedef struct packed {
    logic [28:0] rem;
    logic [28:0] res;
  } root_t;

  typedef struct packed {
    req_e sel;
    logic neg;
  } tag_t;

  // One digit of the bitwise square root; step k tests the bit 2^(28-2k).
  function automatic root_t root_step(input root_t cur, input int unsigned k);
    logic [28:0] bitv;
    logic [29:0] trial;
    root_t       nxt;
    bitv  = 29'(1) << (28 - 2 * k);
    trial = {1'b0, cur.res} + {1'b0, bitv};
    if ({1'b0, cur.rem} >= trial) begin
      nxt.rem = cur.rem - trial[28:0];
      nxt.res = (cur.res >> 1) + bitv;
    end else begin
      nxt.rem = cur.rem;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: design/arcsin_arccos_poly_sqrt_approx.sv
// An accepted request moves through the stage registers in order and ends in the output register.
// Throughput: one request per cycle while the output is not stalled; the five 3-digit root stages set the depth.
// Each stage holds its data while the next one is full and held, and bubbles close up.
// Reset (rst_ni low, asynchronous) empties every stage; no state outlives a request.
// Depends on asac_pkg and the assertion macro header.
`default_nettype none

`include "arcsin_arccos_poly_sqrt_approx_assert.svh"

module arcsin_arccos_poly_sqrt_approx
  import asac_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] x_value
  input  wire logic        s_axis_tuser,  // [0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [15:0] angle
);

  localparam int unsigned NSTG = 8;

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] en;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    en[NSTG-1] = !valid_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Stage 1: magnitude, saturation to one, radicand.
  logic        in_neg;
  logic [16:0] in_mag;
  logic [14:0] in_a;
  tag_t        s1_tag_q;
  logic [14:0] s1_a_q;
  root_t       s1_root_q;

  assign in_neg = s_axis_tdata[15];
  assign in_mag = in_neg ? (17'h10000 - {1'b0, s_axis_tdata}) : {1'b0, s_axis_tdata};
  assign in_a   = (in_mag > {2'b00, ONE_Q14}) ? ONE_Q14 : in_mag[14:0];

  always_ff @(posedge clk_i) begin
    if (en[0] && s_axis_tvalid) begin
      s1_tag_q      <= '{sel: req_e'(s_axis_tuser), neg: in_neg};
      s1_a_q        <= in_a;
      s1_root_q.rem <= {ONE_Q14 - in_a, 14'd0};
      s1_root_q.res <= '0;
    end
  end

  // Stage 2: root digits 0..2, first Horner product.
  root_t       s2_root_d;
  tag_t        s2_tag_q;
  logic [14:0] s2_a_q;
  root_t       s2_root_q;
  logic [25:0] s2_p1_q;

  always_comb begin
    s2_root_d = s1_root_q;
    for (int unsigned k = 0; k < STEPS_PER_STG; k++) begin
      s2_root_d = root_step(s2_root_d, k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && valid_q[0]) begin
      s2_tag_q  <= s1_tag_q;
      s2_a_q    <= s1_a_q;
      s2_root_q <= s2_root_d;
      s2_p1_q   <= 26'(COEF3) * 26'(s1_a_q);
    end
  end

  // Stage 3: root digits 3..5, h1 and its product with a.
  root_t       s3_root_d;
  logic [10:0] s3_rnd;
  logic [12:0] s3_h1;
  tag_t        s3_tag_q;
  logic [14:0] s3_a_q;
  root_t       s3_root_q;
  logic [27:0] s3_p2_q;

  always_comb begin
    s3_root_d = s2_root_q;
    for (int unsigned k = STEPS_PER_STG; k < 2 * STEPS_PER_STG; k++) begin
      s3_root_d = root_step(s3_root_d, k);
    end
  end

  assign s3_rnd = 11'((27'(s2_p1_q) + 27'd8192) >> 14);
  assign s3_h1  = COEF2 - 13'(s3_rnd);

  always_ff @(posedge clk_i) begin
    if (en[2] && valid_q[1]) begin
      s3_tag_q  <= s2_tag_q;
      s3_a_q    <= s2_a_q;
      s3_root_q <= s3_root_d;
      s3_p2_q   <= 28'(s3_h1) * 28'(s2_a_q);
    end
  end

  // Stage 4: root digits 6..8, h2 and its product with a.
  root_t       s4_root_d;
  logic [12:0] s4_rnd;
  logic [13:0] s4_h2;
  tag_t        s4_tag_q;
  root_t       s4_root_q;
  logic [28:0] s4_p3_q;

  always_comb begin
    s4_root_d = s3_root_q;
    for (int unsigned k = 2 * STEPS_PER_STG; k < 3 * STEPS_PER_STG; k++) begin
      s4_root_d = root_step(s4_root_d, k);
    end
  end

  assign s4_rnd = 13'((29'(s3_p2_q) + 29'd8192) >> 14);
  assign s4_h2  = COEF1 - 14'(s4_rnd);

  always_ff @(posedge clk_i) begin
    if (en[3] && valid_q[2]) begin
      s4_tag_q  <= s3_tag_q;
      s4_root_q <= s4_root_d;
      s4_p3_q   <= 29'(s4_h2) * 29'(s3_a_q);
    end
  end

  // Stage 5: root digits 9..11, h3.
  root_t       s5_root_d;
  logic [13:0] s5_rnd;
  tag_t        s5_tag_q;
  root_t       s5_root_q;
  logic [16:0] s5_h3_q;

  always_comb begin
    s5_root_d = s4_root_q;
    for (int unsigned k = 3 * STEPS_PER_STG; k < 4 * STEPS_PER_STG; k++) begin
      s5_root_d = root_step(s5_root_d, k);
    end
  end

  assign s5_rnd = 14'((30'(s4_p3_q) + 30'd8192) >> 14);

  always_ff @(posedge clk_i) begin
    if (en[4] && valid_q[3]) begin
      s5_tag_q  <= s4_tag_q;
      s5_root_q <= s5_root_d;
      s5_h3_q   <= COEF0 - 17'(s5_rnd);
    end
  end

  // Stage 6: last root digits; the root is at most 1.0 and fits in 15 bits.
  root_t       s6_root_d;
  tag_t        s6_tag_q;
  logic [14:0] s6_s_q;
  logic [16:0] s6_h3_q;

  always_comb begin
    s6_root_d = s5_root_q;
    for (int unsigned k = 4 * STEPS_PER_STG; k < ROOT_STEPS; k++) begin
      s6_root_d = root_step(s6_root_d, k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5] && valid_q[4]) begin
      s6_tag_q <= s5_tag_q;
      s6_s_q   <= s6_root_d.res[14:0];
      s6_h3_q  <= s5_h3_q;
    end
  end

  // Stage 7: root times polynomial.
  tag_t        s7_tag_q;
  logic [31:0] s7_prod_q;

  always_ff @(posedge clk_i) begin
    if (en[6] && valid_q[5]) begin
      s7_tag_q  <= s6_tag_q;
      s7_prod_q <= 32'(s6_s_q) * 32'(s6_h3_q);
    end
  end

  // Stage 8: round to Q3.13 and fold into the requested quadrant.
  logic [14:0]        s8_t;
  logic signed [15:0] s8_ts;
  logic signed [15:0] s8_angle_d;
  logic signed [15:0] s8_angle_q;

  assign s8_t  = 15'((33'(s7_prod_q) + 33'd65536) >> 17);
  assign s8_ts = signed'({1'b0, s8_t});

  always_comb begin
    case (s7_tag_q.sel)
      REQ_ACOS: s8_angle_d = s7_tag_q.neg ? (PI_Q13 - s8_ts) : s8_ts;
      REQ_ASIN: s8_angle_d = s7_tag_q.neg ? (s8_ts - HALF_PI_Q13) : (HALF_PI_Q13 - s8_ts);
      default:  s8_angle_d = s8_ts;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[7] && valid_q[6]) begin
      s8_angle_q <= s8_angle_d;
    end
  end

  assign m_axis_tvalid = valid_q[NSTG-1];
  assign m_axis_tdata  = s8_angle_q;

  // An empty output register means the whole pipeline can move.
  `ASAC_ASSERT_IMP(a_ready_when_out_empty, clk_i, rst_ni, !valid_q[NSTG-1], s_axis_tready, "input stalled while output register empty")

  // The cubic stays between 89038 and its value at zero.
  `ASAC_ASSERT_IMP(a_h3_range, clk_i, rst_ni, valid_q[4], (s5_h3_q >= 17'd89038) && (s5_h3_q <= COEF0), "polynomial value out of range")

  // The root of a Q0.14 value never exceeds one.
  `ASAC_ASSERT_IMP(a_root_range, clk_i, rst_ni, valid_q[5], s6_s_q <= ONE_Q14, "square root above one")

  // A freshly loaded result lies between minus pi/2 and pi.
  `ASAC_ASSERT_NXT(a_angle_range, clk_i, rst_ni, valid_q[6] && en[7], ($signed(m_axis_tdata) >= -16'sd12868) && ($signed(m_axis_tdata) <= PI_Q13), "angle out of range")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the arcsine/arccosine pipeline arcsin_arccos_poly_sqrt_approx.
// Depends on asac_pkg for the request kind and on the block itself; it reads no files.
`timescale 1ns / 1ps

module testbench;
  import asac_pkg::*;

  typedef struct {
    req_e        kind;
    logic [15:0] x;
    logic        wait_idle;  // hold this request back until the pipeline has drained
  } angle_req_t;

  typedef struct {
    req_e        kind;
    logic [15:0] x;
    logic [15:0] angle;
  } angle_exp_t;

  localparam int unsigned NUM_RANDOM = 1650;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] x_value
  logic        s_axis_tuser = 1'b0; // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] angle

  angle_req_t pending_reqs[$];
  angle_exp_t angle_fifo[$];
  angle_req_t cur_req;

  logic [3:0] send_gap = '0;
  logic       send_burst = 1'b0;
  logic [3:0] recv_stall = '0;
  logic       recv_burst = 1'b0;
  int         next_stall;

  int mismatch_count = 0;
  int n_checked = 0;
  int n_acos = 0;
  int n_asin = 0;
  int n_beyond = 0;

  arcsin_arccos_poly_sqrt_approx u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Integer floor square root built one bit at a time from the top.
  function automatic longint isqrt_floor(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 14; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // t = sqrt(1 - a) * (((c2 - c3*a)*a - c1)*a + c0), with a = min(|x|, 1).
  function automatic logic [15:0] predict_angle(req_e kind, logic [15:0] x);
    logic        neg;
    logic [16:0] mag;
    longint      a, s, h1, h2, h3, t, ang;
    neg = x[15];
    mag = neg ? (17'h10000 - {1'b0, x}) : {1'b0, x};
    a   = (mag > 17'd16384) ? 64'sd16384 : longint'(mag);
    s   = isqrt_floor((16384 - a) << 14);
    h1  = 4867 - ((1227 * a + 8192) >>> 14);
    h2  = 13901 - ((h1 * a + 8192) >>> 14);
    h3  = 102939 - ((h2 * a + 8192) >>> 14);
    t   = (s * h3 + 65536) >>> 17;
    if (kind == REQ_ACOS) ang = neg ? (25736 - t) : t;
    else                  ang = neg ? (t - 12868) : (12868 - t);
    return ang[15:0];
  endfunction

  // Request driver: a random gap after each request, with bursts that have none.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        angle_fifo.push_back('{cur_req.kind, cur_req.x, predict_angle(cur_req.kind, cur_req.x)});
        if (cur_req.kind == REQ_ACOS) n_acos++;
        else n_asin++;
        if (cur_req.x[15] ? (cur_req.x < 16'hC000) : (cur_req.x > 16'h4000)) n_beyond++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1'b1;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].wait_idle && angle_fifo.size() != 0)) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_req.x;
          s_axis_tuser  <= cur_req.kind;
          send_gap      <= send_burst ? 4'd0 : 4'($urandom_range(0, 9));
          if ($urandom_range(0, 63) == 0) send_burst <= ~send_burst;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares every result with the oldest expected angle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= '0;
    end else begin
      next_stall = recv_stall;
      if (m_axis_tvalid && m_axis_tready) begin
        if (angle_fifo.size() == 0) begin
          $display("%0t: unexpected result, got %0d", $time, $signed(m_axis_tdata));
          mismatch_count++;
        end else begin
          if (m_axis_tdata !== angle_fifo[0].angle) begin
            $display("%0t: angle mismatch for %s x=%0d, expected %0d, got %0d", $time,
                     angle_fifo[0].kind.name(), $signed(angle_fifo[0].x),
                     $signed(angle_fifo[0].angle), $signed(m_axis_tdata));
            mismatch_count++;
          end
          void'(angle_fifo.pop_front());
          n_checked++;
        end
        next_stall = recv_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 63) == 0) recv_burst <= ~recv_burst;
      end
      if (next_stall != 0) begin
        m_axis_tready <= 1'b0;
        recv_stall    <= 4'(next_stall - 1);
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall    <= '0;
      end
    end
  end

  initial begin
    angle_req_t  item;
    int          mode;
    int          v;
    logic [15:0] edge_vals[12];
    edge_vals = '{16'h0000, 16'h4000, 16'hC000, 16'h3FFF, 16'hC001, 16'h0001,
                  16'hFFFF, 16'h4001, 16'h8000, 16'h7FFF, 16'h2000, 16'hE000};

    // Directed part: extremes, both signs, saturation and both functions.
    foreach (edge_vals[i]) begin
      item.kind = REQ_ACOS;
      item.x = edge_vals[i];
      item.wait_idle = 1'b0;
      pending_reqs.push_back(item);
      item.kind = REQ_ASIN;
      pending_reqs.push_back(item);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        v = int'($urandom_range(0, 32768)) - 16384;
      end else if (mode == 6) begin
        v = 16384 - int'($urandom_range(0, 48));
        if ($urandom_range(0, 1)) v = -v;
      end else if (mode == 7) begin
        // Magnitude above one, which the block saturates.
        v = 16385 + int'($urandom_range(0, 16382));
        if ($urandom_range(0, 1)) v = -v;
      end else if (mode == 8) begin
        v = int'($urandom_range(0, 63));
        if ($urandom_range(0, 1)) v = -v;
      end else begin
        v = int'($urandom_range(0, 65535));
      end
      item.kind = req_e'($urandom_range(0, 1));
      item.x = v[15:0];
      item.wait_idle = (i == 0) || (i == NUM_RANDOM / 2);
      pending_reqs.push_back(item);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid || angle_fifo.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d arccos and %0d arcsin requests, %0d of them",
             n_checked, n_acos, n_asin, n_beyond);
    $display("with the argument beyond unit magnitude; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0 && angle_fifo.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/asac_pkg.sv
design/arcsin_arccos_poly_sqrt_approx.sv
tb/sv/testbench.sv
